// ===== design/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Field widths, the job table entry layout and the control group passed to
// the selection unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int ARR_W     = 10;
  localparam int BURST_W   = 8;
  localparam int LVL_W     = 8;
  localparam int TIME_W    = 13;
  localparam int OUT_IDX_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One row of the job table.
  typedef struct packed {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] rem;
    logic [LVL_W-1:0]   lvl;
    logic [TIME_W-1:0]  start;
    logic               started;
  } job_entry_t;

  // Control from the sequencer to the selection unit.
  typedef struct packed {
    logic clear;
    logic cand_vld;
  } pick_ctl_t;

endpackage

// ===== design/pps_if.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler channels
// Valid/ready channels for job words in and completion words out.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::ARR_W-1:0]   arrival_time;
  logic [pps_pkg::BURST_W-1:0] burst_length;
  logic [pps_pkg::LVL_W-1:0]   priority_level;
  logic                        last_job;

  modport source (output valid, arrival_time, burst_length, priority_level, last_job,
                  input ready);
  modport sink (input valid, arrival_time, burst_length, priority_level, last_job,
                output ready);
endinterface

interface pps_out_if;
  logic                          valid;
  logic                          ready;
  logic [pps_pkg::OUT_IDX_W-1:0] job_index;
  logic [pps_pkg::TIME_W-1:0]    start_time;
  logic [pps_pkg::TIME_W-1:0]    finish_time;
  logic [pps_pkg::TIME_W-1:0]    turnaround;
  logic                          last_result;

  modport source (output valid, job_index, start_time, finish_time, turnaround, last_result,
                  input ready);
  modport sink (input valid, job_index, start_time, finish_time, turnaround, last_result,
                output ready);
endinterface

// ===== design/pps_pick.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler selection unit
// Keeps the best ready job seen so far while the job table is scanned.
// ----------------------------------------------------------------------------
module pps_pick #(
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pps_pkg::pick_ctl_t           ctl,
  input  logic [IDX_W-1:0]             cand_idx,
  input  pps_pkg::job_entry_t          cand,
  input  logic [pps_pkg::TIME_W-1:0]   clock_now,
  output logic                         best_vld,
  output logic [IDX_W-1:0]             best_idx,
  output pps_pkg::job_entry_t          best
);

  logic                best_vld_r;
  logic [IDX_W-1:0]    best_idx_r;
  pps_pkg::job_entry_t best_r;
  logic                cand_ready;
  logic                better;
  logic                take;

  // A job is ready once it has arrived and still needs service.
  assign cand_ready = ({{(pps_pkg::TIME_W - pps_pkg::ARR_W){1'b0}}, cand.arr} <= clock_now) &&
                      (cand.rem != '0);

  // Strict compare: on a full tie the earlier scanned (lower) index stays.
  assign better = !best_vld_r || (cand.lvl < best_r.lvl) ||
                  ((cand.lvl == best_r.lvl) && (cand.arr < best_r.arr));

  assign take = ctl.cand_vld && cand_ready && better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (ctl.clear) begin
      best_vld_r <= 1'b0;
    end else if (take) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_idx_r <= cand_idx;
      best_r     <= cand;
    end
  end

  assign best_vld = best_vld_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads a table of jobs, then runs a preemptive priority schedule over it and
// reports each job as it completes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one job per word. Words are taken one per cycle into the
//   job table while the block is loading. A word with last_job set closes the
//   table and starts the schedule; in_ch.ready stays low until the last
//   completion word of that table has been produced. Jobs beyond MAX_JOBS
//   are dropped, but their last_job flag still starts the schedule.
//   out_ch carries one word per completed job, in completion order, and
//   last_result marks the final one of the table.
//   Timing: each simulated time unit is one pass over the job table through
//   its single read port, scanned one entry a cycle, after which the
//   registered read is compared and the chosen entry is written back.
//   The completion word sits in an output register. A stalled receiver
//   holds the schedule only when a further completion is ready; after the
//   final completion the block returns to loading at once.
//   Reset (rst_n low, synchronous) empties the table, zeroes the time and
//   returns the block to loading; no clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] JOBS_FULL = CNT_W'(MAX_JOBS);

  typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_UPDATE} state_t;

  state_t state_r;

  // Bookkeeping registers.
  logic [CNT_W-1:0]           job_count_r;
  logic [CNT_W-1:0]           done_count_r;
  logic [pps_pkg::TIME_W-1:0] clock_now_r;
  logic [CNT_W-1:0]           rd_idx_r;
  logic                       rd_vld_r;
  logic [IDX_W-1:0]           rd_tag_r;

  // Job table: one write port, one registered read port.
  pps_pkg::job_entry_t job_mem [MAX_JOBS];
  pps_pkg::job_entry_t mem_q_r;
  logic                mem_re;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  pps_pkg::job_entry_t mem_wdata;

  // Output register.
  logic                          out_valid_r;
  logic [pps_pkg::OUT_IDX_W-1:0] out_index_r;
  logic [pps_pkg::TIME_W-1:0]    out_start_r;
  logic [pps_pkg::TIME_W-1:0]    out_finish_r;
  logic [pps_pkg::TIME_W-1:0]    out_turn_r;
  logic                          out_last_r;

  // Selection unit.
  pps_pkg::pick_ctl_t  pick_ctl;
  logic                best_vld;
  logic [IDX_W-1:0]    best_idx;
  pps_pkg::job_entry_t best;

  // Datapath helpers.
  logic                             in_acc;
  logic                             store_en;
  pps_pkg::job_entry_t              load_entry;
  pps_pkg::job_entry_t              upd_entry;
  logic [pps_pkg::BURST_W-1:0]      rem_dec;
  logic                             is_done;
  logic [pps_pkg::TIME_W-1:0]       clock_nxt;
  logic [pps_pkg::TIME_W-1:0]       turn_nxt;
  logic [CNT_W-1:0]                 done_nxt;
  logic                             is_final;
  logic                             upd_stall;
  logic                             upd_go;
  logic                             out_load;
  logic [IDX_W+pps_pkg::OUT_IDX_W-1:0] idx_ext;

  // Load side.
  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign store_en    = in_acc && (job_count_r != JOBS_FULL);

  // A zero burst is served as a single unit.
  assign load_entry.arr     = in_ch.arrival_time;
  assign load_entry.rem     = (in_ch.burst_length == '0) ?
                              pps_pkg::BURST_W'(1) : in_ch.burst_length;
  assign load_entry.lvl     = in_ch.priority_level;
  assign load_entry.start   = '0;
  assign load_entry.started = 1'b0;

  // Update of the chosen job for one time unit.
  assign rem_dec   = best.rem - pps_pkg::BURST_W'(1);
  assign is_done   = (rem_dec == '0);
  assign clock_nxt = (clock_now_r == pps_pkg::TIME_MAX) ?
                     clock_now_r : clock_now_r + pps_pkg::TIME_W'(1);
  assign turn_nxt  = clock_nxt -
                     {{(pps_pkg::TIME_W - pps_pkg::ARR_W){1'b0}}, best.arr};
  assign done_nxt  = done_count_r + CNT_W'(1);
  assign is_final  = (done_nxt == job_count_r);
  assign idx_ext   = {{pps_pkg::OUT_IDX_W{1'b0}}, best_idx};

  assign upd_entry.arr     = best.arr;
  assign upd_entry.rem     = rem_dec;
  assign upd_entry.lvl     = best.lvl;
  assign upd_entry.start   = best.started ? best.start : clock_now_r;
  assign upd_entry.started = 1'b1;

  // A completion waits while the previous one is still unclaimed.
  assign upd_stall = best_vld && is_done && out_valid_r && !out_ch.ready;
  assign upd_go    = (state_r == ST_UPDATE) && !upd_stall;
  assign out_load  = upd_go && best_vld && is_done;

  assign mem_re    = (state_r == ST_SCAN) && (rd_idx_r < job_count_r);
  assign mem_we    = store_en || (upd_go && best_vld);
  assign mem_waddr = store_en ? job_count_r[IDX_W-1:0] : best_idx;
  assign mem_wdata = store_en ? load_entry : upd_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      job_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= job_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign pick_ctl.clear    = (state_r == ST_LOAD) || upd_go;
  assign pick_ctl.cand_vld = (state_r == ST_SCAN) && rd_vld_r;

  pps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .cand_idx  (rd_tag_r),
    .cand      (mem_q_r),
    .clock_now (clock_now_r),
    .best_vld  (best_vld),
    .best_idx  (best_idx),
    .best      (best)
  );

  // Sequencer: load, scan the table, then advance one time unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      job_count_r  <= '0;
      done_count_r <= '0;
      clock_now_r  <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // A word taken in the same cycle as a new completion is replaced by it.
      if (out_ch.valid && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_en) begin
              job_count_r <= job_count_r + CNT_W'(1);
            end
            if (in_ch.last_job) begin
              state_r  <= ST_SCAN;
              rd_idx_r <= '0;
              rd_vld_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_r <= mem_re;
          rd_tag_r <= rd_idx_r[IDX_W-1:0];
          if (mem_re) begin
            rd_idx_r <= rd_idx_r + CNT_W'(1);
          end
          // The last read compares in this cycle.
          if (rd_idx_r == job_count_r) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_go) begin
            rd_idx_r <= '0;
            rd_vld_r <= 1'b0;
            if (out_load) begin
              out_valid_r  <= 1'b1;
              out_index_r  <= idx_ext[pps_pkg::OUT_IDX_W-1:0];
              out_start_r  <= upd_entry.start;
              out_finish_r <= clock_nxt;
              out_turn_r   <= turn_nxt;
              out_last_r   <= is_final;
              if (is_final) begin
                job_count_r  <= '0;
                done_count_r <= '0;
                clock_now_r  <= '0;
                state_r      <= ST_LOAD;
              end else begin
                done_count_r <= done_nxt;
                clock_now_r  <= clock_nxt;
                state_r      <= ST_SCAN;
              end
            end else begin
              clock_now_r <= clock_nxt;
              state_r     <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.job_index   = out_index_r;
  assign out_ch.start_time  = out_start_r;
  assign out_ch.finish_time = out_finish_r;
  assign out_ch.turnaround  = out_turn_r;
  assign out_ch.last_result = out_last_r;

`ifndef ASSERT_OFF
  // No more jobs can complete than were loaded.
  a_done_le_jobs : assert property (@(posedge clk) disable iff (!rst_n)
    done_count_r <= job_count_r)
    else $error("completion count exceeds job count");

  // The final completion empties the table and returns to loading.
  a_final_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && best_vld && is_done && is_final) |=>
      (job_count_r == '0) && (state_r == ST_LOAD) && out_valid_r)
    else $error("table not cleared after final completion");

  // The table is never written while it is being scanned.
  a_no_write_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("job table written during scan");

  // Time only moves forward during a schedule.
  a_time_forward : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |=> (clock_now_r >= $past(clock_now_r)) || (state_r == ST_LOAD))
    else $error("time went backward during schedule");

  // A chosen job always has service left when it is updated.
  a_best_has_work : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPDATE) && best_vld) |-> (best.rem != '0))
    else $error("chosen job has no remaining service");
`endif

endmodule
